[rtl/core/speq_pkg.sv]
// ----------------------------------------------------------------------------
// Stereo peaking equaliser package
// Shared types, register codes and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package speq_pkg;

  localparam int DELAY_W   = 32;
  localparam int COEF_W    = 26;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ZERO     = 3'd0,
    REG_NUM_ONE      = 3'd1,
    REG_NUM_TWO      = 3'd2,
    REG_DEN_ONE      = 3'd3,
    REG_DEN_TWO      = 3'd4,
    REG_INV_NUM_ZERO = 3'd5,
    REG_BOOST_MODE   = 3'd6,
    REG_BYPASS       = 3'd7
  } cfg_reg_t;

  typedef logic signed [COEF_W-1:0] coef_word_t;

  typedef struct packed {
    coef_word_t num_zero;
    coef_word_t num_one;
    coef_word_t num_two;
    coef_word_t den_one;
    coef_word_t den_two;
    coef_word_t inv_num_zero;
  } coef_set_t;

  typedef enum logic [1:0] {
    OPA_M0,
    OPA_M1,
    OPA_W,
    OPA_T
  } opa_sel_t;

  typedef enum logic [2:0] {
    CF_B0,
    CF_B1,
    CF_B2,
    CF_A1,
    CF_A2,
    CF_INV
  } coef_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_PROD,
    ACC_ADD,
    ACC_SUB,
    ACC_SHX,
    ACC_SHW
  } acc_op_t;

  typedef enum logic [1:0] {
    LAT_NONE,
    LAT_W_CUT,
    LAT_W_BOOST,
    LAT_T
  } lat_op_t;

  typedef struct packed {
    logic      capture;
    opa_sel_t  opa;
    coef_sel_t coef;
    acc_op_t   acc_op;
    lat_op_t   lat;
    logic      finish;
    logic      pass;
    logic      update;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CUT0, S_CUT1, S_CUT2, S_CUT3, S_CUT4, S_CUT5, S_CUT6,
    S_BST0, S_BST1, S_BST2, S_BST3, S_BST4, S_BST5, S_BST6,
    S_BST7, S_BST8, S_BST9, S_BST10, S_BST11, S_BST12,
    S_FIN
  } state_t;

endpackage

[rtl/core/speq_ctrl.sv]
// ----------------------------------------------------------------------------
// Stereo peaking equaliser controller
// Sequences the shared multiplier and accumulator through the cut or boost
// recursion, one product per cycle, and hands each word to the output stage.
// ----------------------------------------------------------------------------
module speq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              boost_mode,
  input  logic              bypass,
  input  speq_pkg::status_t status,
  output speq_pkg::cmd_t    cmd
);

  speq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= speq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.opa     = speq_pkg::OPA_M0;
    cmd.coef    = speq_pkg::CF_B0;
    cmd.acc_op  = speq_pkg::ACC_HOLD;
    cmd.lat     = speq_pkg::LAT_NONE;
    cmd.finish  = 1'b0;
    cmd.pass    = 1'b0;
    cmd.update  = 1'b0;
    case (state)
      speq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (bypass) begin
            state_next = speq_pkg::S_FIN;
          end else if (boost_mode) begin
            state_next = speq_pkg::S_BST0;
          end else begin
            state_next = speq_pkg::S_CUT0;
          end
        end
      end
      speq_pkg::S_CUT0: begin
        cmd.acc_op = speq_pkg::ACC_SHX;
        cmd.opa    = speq_pkg::OPA_M0;
        cmd.coef   = speq_pkg::CF_A1;
        state_next = speq_pkg::S_CUT1;
      end
      speq_pkg::S_CUT1: begin
        cmd.acc_op = speq_pkg::ACC_SUB;
        cmd.opa    = speq_pkg::OPA_M1;
        cmd.coef   = speq_pkg::CF_A2;
        state_next = speq_pkg::S_CUT2;
      end
      speq_pkg::S_CUT2: begin
        cmd.acc_op = speq_pkg::ACC_SUB;
        state_next = speq_pkg::S_CUT3;
      end
      speq_pkg::S_CUT3: begin
        cmd.lat    = speq_pkg::LAT_W_CUT;
        cmd.opa    = speq_pkg::OPA_M0;
        cmd.coef   = speq_pkg::CF_B1;
        state_next = speq_pkg::S_CUT4;
      end
      speq_pkg::S_CUT4: begin
        cmd.acc_op = speq_pkg::ACC_PROD;
        cmd.opa    = speq_pkg::OPA_M1;
        cmd.coef   = speq_pkg::CF_B2;
        state_next = speq_pkg::S_CUT5;
      end
      speq_pkg::S_CUT5: begin
        cmd.acc_op = speq_pkg::ACC_ADD;
        cmd.opa    = speq_pkg::OPA_W;
        cmd.coef   = speq_pkg::CF_B0;
        state_next = speq_pkg::S_CUT6;
      end
      speq_pkg::S_CUT6: begin
        cmd.acc_op = speq_pkg::ACC_ADD;
        state_next = speq_pkg::S_FIN;
      end
      speq_pkg::S_BST0: begin
        cmd.opa    = speq_pkg::OPA_M0;
        cmd.coef   = speq_pkg::CF_B1;
        state_next = speq_pkg::S_BST1;
      end
      speq_pkg::S_BST1: begin
        cmd.acc_op = speq_pkg::ACC_PROD;
        cmd.opa    = speq_pkg::OPA_M1;
        cmd.coef   = speq_pkg::CF_B2;
        state_next = speq_pkg::S_BST2;
      end
      speq_pkg::S_BST2: begin
        cmd.acc_op = speq_pkg::ACC_ADD;
        state_next = speq_pkg::S_BST3;
      end
      speq_pkg::S_BST3: begin
        cmd.lat    = speq_pkg::LAT_T;
        state_next = speq_pkg::S_BST4;
      end
      speq_pkg::S_BST4: begin
        cmd.opa    = speq_pkg::OPA_T;
        cmd.coef   = speq_pkg::CF_INV;
        state_next = speq_pkg::S_BST5;
      end
      speq_pkg::S_BST5: begin
        cmd.acc_op = speq_pkg::ACC_PROD;
        state_next = speq_pkg::S_BST6;
      end
      speq_pkg::S_BST6: begin
        cmd.lat    = speq_pkg::LAT_W_BOOST;
        state_next = speq_pkg::S_BST7;
      end
      speq_pkg::S_BST7: begin
        cmd.acc_op = speq_pkg::ACC_SHW;
        cmd.opa    = speq_pkg::OPA_M0;
        cmd.coef   = speq_pkg::CF_A1;
        state_next = speq_pkg::S_BST8;
      end
      speq_pkg::S_BST8: begin
        cmd.acc_op = speq_pkg::ACC_ADD;
        cmd.opa    = speq_pkg::OPA_M1;
        cmd.coef   = speq_pkg::CF_A2;
        state_next = speq_pkg::S_BST9;
      end
      speq_pkg::S_BST9: begin
        cmd.acc_op = speq_pkg::ACC_ADD;
        state_next = speq_pkg::S_BST10;
      end
      speq_pkg::S_BST10: begin
        cmd.lat    = speq_pkg::LAT_T;
        state_next = speq_pkg::S_BST11;
      end
      speq_pkg::S_BST11: begin
        cmd.opa    = speq_pkg::OPA_T;
        cmd.coef   = speq_pkg::CF_INV;
        state_next = speq_pkg::S_BST12;
      end
      speq_pkg::S_BST12: begin
        cmd.acc_op = speq_pkg::ACC_PROD;
        state_next = speq_pkg::S_FIN;
      end
      speq_pkg::S_FIN: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          cmd.pass   = bypass;
          cmd.update = !bypass;
          state_next = speq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = speq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/speq_dpath.sv]
// ----------------------------------------------------------------------------
// Stereo peaking equaliser datapath
// Delay words per channel, one shared multiplier with a product register, an
// accumulator with rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module speq_dpath #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22,
  parameter int CHANNELS       = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  speq_pkg::cmd_t                cmd,
  output speq_pkg::status_t             status,
  input  speq_pkg::coef_set_t           coef,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          channel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          channel_out
);

  localparam int DW     = speq_pkg::DELAY_W;
  localparam int PROD_W = DW + speq_pkg::COEF_W;
  localparam int SH_W   = DW + COEF_FRAC_BITS;
  localparam int ACC_W  = ((PROD_W > SH_W) ? PROD_W : SH_W) + 2;
  localparam int EXT_W  = ACC_W + 2;
  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [EXT_W-1:0] HALF =
    {{(EXT_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  logic signed [DW-1:0]     m0_st [CHANNELS];
  logic signed [DW-1:0]     m1_st [CHANNELS];
  logic signed [DW-1:0]     x_reg;
  logic signed [DW-1:0]     m0;
  logic signed [DW-1:0]     m1;
  logic signed [DW-1:0]     w_reg;
  logic signed [DW-1:0]     t_reg;
  logic                     ch_reg;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         in_idx;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [DW-1:0]     opa_val;
  speq_pkg::coef_word_t     coef_val;
  logic signed [EXT_W-1:0]  rq;
  logic signed [EXT_W-1:0]  diff;

  function automatic logic signed [EXT_W-1:0] round_q(input logic signed [ACC_W-1:0] v);
    logic signed [EXT_W-1:0] s;
    s = EXT_W'(v) + HALF;
    return s >>> COEF_FRAC_BITS;
  endfunction

  function automatic logic signed [DW-1:0] sat_word(input logic signed [EXT_W-1:0] v);
    logic [EXT_W-DW:0] hi;
    hi = v[EXT_W-1:DW-1];
    if (&hi || ~|hi) begin
      return v[DW-1:0];
    end else if (v[EXT_W-1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [EXT_W-1:0] v
  );
    logic [EXT_W-SAMPLE_BITS:0] hi;
    hi = v[EXT_W-1:SAMPLE_BITS-1];
    if (&hi || ~|hi) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[EXT_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  assign in_idx = (CHANNELS == 1) ? '0 : IDX_W'(channel);
  assign status.out_full = out_valid && !out_ready;

  always_comb begin
    case (cmd.opa)
      speq_pkg::OPA_M0: opa_val = m0;
      speq_pkg::OPA_M1: opa_val = m1;
      speq_pkg::OPA_W:  opa_val = w_reg;
      speq_pkg::OPA_T:  opa_val = t_reg;
      default:          opa_val = m0;
    endcase
  end

  always_comb begin
    case (cmd.coef)
      speq_pkg::CF_B0:  coef_val = coef.num_zero;
      speq_pkg::CF_B1:  coef_val = coef.num_one;
      speq_pkg::CF_B2:  coef_val = coef.num_two;
      speq_pkg::CF_A1:  coef_val = coef.den_one;
      speq_pkg::CF_A2:  coef_val = coef.den_two;
      speq_pkg::CF_INV: coef_val = coef.inv_num_zero;
      default:          coef_val = coef.num_zero;
    endcase
  end

  always_comb begin
    case (cmd.acc_op)
      speq_pkg::ACC_HOLD: acc_next = acc;
      speq_pkg::ACC_PROD: acc_next = ACC_W'(prod);
      speq_pkg::ACC_ADD:  acc_next = acc + ACC_W'(prod);
      speq_pkg::ACC_SUB:  acc_next = acc - ACC_W'(prod);
      speq_pkg::ACC_SHX:  acc_next = ACC_W'(x_reg) <<< COEF_FRAC_BITS;
      speq_pkg::ACC_SHW:  acc_next = ACC_W'(w_reg) <<< COEF_FRAC_BITS;
      default:            acc_next = acc;
    endcase
  end

  assign rq   = round_q(acc);
  assign diff = EXT_W'(x_reg) - rq;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(opa_val) * PROD_W'(coef_val);
    acc  <= acc_next;
    if (cmd.capture) begin
      x_reg  <= DW'(sample_in);
      ch_reg <= channel;
      idx    <= in_idx;
      m0     <= m0_st[in_idx];
      m1     <= m1_st[in_idx];
    end
    case (cmd.lat)
      speq_pkg::LAT_NONE:    ;
      speq_pkg::LAT_W_CUT:   w_reg <= sat_word(rq);
      speq_pkg::LAT_W_BOOST: w_reg <= sat_word(diff);
      speq_pkg::LAT_T:       t_reg <= sat_word(rq);
      default:               ;
    endcase
    if (cmd.finish) begin
      sample_out  <= cmd.pass ? x_reg[SAMPLE_BITS-1:0] : sat_sample(rq);
      channel_out <= ch_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        m0_st[i] <= '0;
        m1_st[i] <= '0;
      end
    end else if (cmd.update) begin
      m0_st[idx] <= w_reg;
      m1_st[idx] <= m0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && !out_ready))
    else $error("Result written over a word still waiting at the output.");

  a_capture_apart: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !cmd.finish && !cmd.update)
    else $error("New sample taken while a result is being retired.");

  a_writeback: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> m0_st[idx] == $past(w_reg) && m1_st[idx] == $past(m0))
    else $error("Delay words not updated for the current channel.");
`endif

endmodule

[rtl/core/stereo_peaking_eq_biquad.sv]
// ----------------------------------------------------------------------------
// Stereo peaking equaliser biquad
// Two-channel direct form II peaking filter with cut, boost and bypass modes,
// one shared multiplier, fixed-point coefficients and saturated outputs.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   sample_in, channel
//   output   out_valid / out_ready sample_out, channel_out
//   config   cfg_we                cfg_index, cfg_data
//
// A cut-mode or boost-mode sample is worked through the single multiplier,
// which issues one product per cycle; a bypassed sample skips the multiplier.
// One sample is in work at a time; the output register holds a finished word
// while the next sample is taken, and a full output stalls only the last step.
// Reset clears the delay words, loads the default coefficients and selects bypass.
// ----------------------------------------------------------------------------
module stereo_peaking_eq_biquad #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22,
  parameter int CHANNELS       = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in,
  input  logic                                  channel,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         sample_out,
  output logic                                  channel_out,
  input  logic                                  cfg_we,
  input  logic [speq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [speq_pkg::COEF_W-1:0]           cfg_data
);

  localparam speq_pkg::coef_word_t COEF_UNITY =
    speq_pkg::coef_word_t'(64'sd1 << COEF_FRAC_BITS);

  speq_pkg::coef_set_t coef;
  logic                boost_mode;
  logic                bypass;
  speq_pkg::cmd_t      cmd;
  speq_pkg::status_t   status;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.num_zero     <= COEF_UNITY;
      coef.num_one      <= '0;
      coef.num_two      <= '0;
      coef.den_one      <= '0;
      coef.den_two      <= '0;
      coef.inv_num_zero <= COEF_UNITY;
      boost_mode        <= 1'b0;
      bypass            <= 1'b1;
    end else if (cfg_we) begin
      case (speq_pkg::cfg_reg_t'(cfg_index))
        speq_pkg::REG_NUM_ZERO:     coef.num_zero     <= cfg_data;
        speq_pkg::REG_NUM_ONE:      coef.num_one      <= cfg_data;
        speq_pkg::REG_NUM_TWO:      coef.num_two      <= cfg_data;
        speq_pkg::REG_DEN_ONE:      coef.den_one      <= cfg_data;
        speq_pkg::REG_DEN_TWO:      coef.den_two      <= cfg_data;
        speq_pkg::REG_INV_NUM_ZERO: coef.inv_num_zero <= cfg_data;
        speq_pkg::REG_BOOST_MODE:   boost_mode        <= cfg_data[0];
        speq_pkg::REG_BYPASS:       bypass            <= cfg_data[0];
        default:                    ;
      endcase
    end
  end

  speq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .boost_mode (boost_mode),
    .bypass     (bypass),
    .status     (status),
    .cmd        (cmd)
  );

  speq_dpath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CHANNELS       (CHANNELS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .coef        (coef),
    .sample_in   (sample_in),
    .channel     (channel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .channel_out (channel_out)
  );

endmodule

[tb/stereo_peaking_eq_biquad_test.sv]
// ----------------------------------------------------------------------------
// Stereo peaking equaliser biquad regression
// Drives tagged samples through the equaliser under bypass, cut and boost
// settings, predicts every output word with a fixed-point filter model kept
// in step with the register writes, and compares the words in order under
// random input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module stereo_peaking_eq_biquad_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS     = 22;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int COEF_W        = speq_pkg::COEF_W;
  localparam int CFG_IDX_W     = speq_pkg::CFG_IDX_W;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7fffff;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic [COEF_W-1:0] COEF_MAX = 26'h1ffffff;
  localparam logic [COEF_W-1:0] COEF_MIN = 26'h2000000;

  // A stable peaking section, usable in both cut and boost modes.
  localparam int STABLE_COEF [6] = '{3774874, -6794772, 3208643, -7549747, 3565158, 4660338};

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          chan;
  } eq_word_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic                          channel   = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          channel_out;
  logic                          cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [COEF_W-1:0]             cfg_data  = '0;

  longint   num_zero_q, num_one_q, num_two_q, den_one_q, den_two_q, inv_num_zero_q;
  logic     boost_q, bypass_q;
  longint   delay_q [4];
  eq_word_t pending_words [$];
  int       errors       = 0;
  int       quiet_cycles = 0;
  int       out_stall    = 0;
  bit       idle_on      = 1'b1;

  stereo_peaking_eq_biquad #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(FRAC_BITS),
    .CHANNELS      (2)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .channel    (channel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .channel_out(channel_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint round_frac(longint v);
    return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic eq_word_t filter_sample(logic signed [SAMPLE_BITS-1:0] x, logic ch);
    longint   xs, m0, m1, w, q, r, y;
    int       base;
    eq_word_t res;
    xs = x;
    base = ch ? 2 : 0;
    res.chan = ch;
    res.sample = x;
    if (!bypass_q) begin
      m0 = delay_q[base];
      m1 = delay_q[base + 1];
      if (!boost_q) begin
        w = clamp(round_frac((xs <<< FRAC_BITS) - den_one_q * m0 - den_two_q * m1), 32);
        y = round_frac(num_zero_q * w + num_one_q * m0 + num_two_q * m1);
      end else begin
        q = clamp(round_frac(num_one_q * m0 + num_two_q * m1), 32);
        w = clamp(xs - round_frac(inv_num_zero_q * q), 32);
        r = clamp(round_frac((w <<< FRAC_BITS) + den_one_q * m0 + den_two_q * m1), 32);
        y = round_frac(inv_num_zero_q * r);
      end
      y = clamp(y, SAMPLE_BITS);
      delay_q[base + 1] = m0;
      delay_q[base] = w;
      res.sample = y[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  task automatic write_reg(speq_pkg::cfg_reg_t idx, logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      speq_pkg::REG_NUM_ZERO:     num_zero_q = $signed(data);
      speq_pkg::REG_NUM_ONE:      num_one_q = $signed(data);
      speq_pkg::REG_NUM_TWO:      num_two_q = $signed(data);
      speq_pkg::REG_DEN_ONE:      den_one_q = $signed(data);
      speq_pkg::REG_DEN_TWO:      den_two_q = $signed(data);
      speq_pkg::REG_INV_NUM_ZERO: inv_num_zero_q = $signed(data);
      speq_pkg::REG_BOOST_MODE:   boost_q = data[0];
      speq_pkg::REG_BYPASS:       bypass_q = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] x, logic ch);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    sample_in = x;
    channel = ch;
    do begin
      @(posedge clk);
    end while (!in_ready);
    pending_words.push_back(filter_sample(x, ch));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_bypass_after_reset();
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample('0, 1'b0);
    send_sample(-24'sd1, 1'b1);
    send_sample(24'sd1, 1'b0);
    send_sample(24'sh555555, 1'b1);
  endtask

  task automatic test_cut_filter();
    wait_idle();
    for (speq_pkg::cfg_reg_t r = speq_pkg::REG_NUM_ZERO; r <= speq_pkg::REG_INV_NUM_ZERO;
         r = r.next())
      write_reg(r, COEF_W'(STABLE_COEF[r]));
    write_reg(speq_pkg::REG_BOOST_MODE, '0);
    write_reg(speq_pkg::REG_BYPASS, '0);
    send_sample(24'sd4194304, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample('0, 1'b1);
    send_sample(-24'sd1, 1'b0);
  endtask

  task automatic test_boost_filter();
    wait_idle();
    write_reg(speq_pkg::REG_BOOST_MODE, COEF_W'(1));
    send_sample(24'sd4194304, 1'b1);
    send_sample('0, 1'b1);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(-24'sd4194304, 1'b1);
    send_sample(24'sd1, 1'b1);
  endtask

  task automatic test_coefficient_saturation();
    wait_idle();
    write_reg(speq_pkg::REG_NUM_ZERO, COEF_MAX);
    write_reg(speq_pkg::REG_NUM_ONE, COEF_MIN);
    write_reg(speq_pkg::REG_NUM_TWO, COEF_MAX);
    write_reg(speq_pkg::REG_DEN_ONE, COEF_MIN);
    write_reg(speq_pkg::REG_DEN_TWO, COEF_MAX);
    write_reg(speq_pkg::REG_INV_NUM_ZERO, COEF_MAX);
    write_reg(speq_pkg::REG_BOOST_MODE, '0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    wait_idle();
    write_reg(speq_pkg::REG_BOOST_MODE, COEF_W'(1));
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    logic [COEF_W-1:0]             data;
    logic signed [SAMPLE_BITS-1:0] x;
    for (int p = 0; p < phases; p++) begin
      wait_idle();
      for (speq_pkg::cfg_reg_t r = speq_pkg::REG_NUM_ZERO; r <= speq_pkg::REG_INV_NUM_ZERO;
           r = r.next()) begin
        if (p == 0 || $urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0: data = COEF_MAX;
            1: data = COEF_MIN;
            2: data = '0;
            3, 4: data = COEF_W'($urandom);
            default: data = COEF_W'(STABLE_COEF[r] + int'($urandom_range(0, 131072)) - 65536);
          endcase
          write_reg(r, data);
        end
      end
      data = COEF_W'($urandom);
      data[0] = 1'($urandom_range(0, 1));
      write_reg(speq_pkg::REG_BOOST_MODE, data);
      data = COEF_W'($urandom);
      data[0] = ($urandom_range(0, 4) == 0);
      write_reg(speq_pkg::REG_BYPASS, data);
      idle_on = (p != phases - 1) && ($urandom_range(0, 3) != 0);
      repeat (per_phase) begin
        case ($urandom_range(0, 9))
          0: x = SAMPLE_MAX;
          1: x = SAMPLE_MIN;
          2, 3, 4: x = SAMPLE_BITS'($urandom_range(0, 2000)) - SAMPLE_BITS'(1000);
          default: x = SAMPLE_BITS'($urandom);
        endcase
        send_sample(x, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready = 1'b0;
      out_stall = out_stall - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_ready = 1'b0;
      out_stall = $urandom_range(0, 5);
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_words
    eq_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual sample %0d channel %0d",
                 $time, sample_out, channel_out);
      end else begin
        want = pending_words.pop_front();
        if (sample_out !== want.sample) begin
          errors++;
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, want.sample, sample_out);
        end
        if (channel_out !== want.chan) begin
          errors++;
          $display("%0t: channel_out mismatch: expected %0d, actual %0d",
                   $time, want.chan, channel_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("stereo_peaking_eq_biquad regression: fail");
      $finish;
    end
  end

  initial begin
    num_zero_q = longint'(1) <<< FRAC_BITS;
    num_one_q = 0;
    num_two_q = 0;
    den_one_q = 0;
    den_two_q = 0;
    inv_num_zero_q = longint'(1) <<< FRAC_BITS;
    boost_q = 1'b0;
    bypass_q = 1'b1;
    foreach (delay_q[i]) delay_q[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_bypass_after_reset();
    test_cut_filter();
    test_boost_filter();
    test_coefficient_saturation();
    test_random_settings(8, 50);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0)
      $display("stereo_peaking_eq_biquad regression: pass");
    else
      $display("stereo_peaking_eq_biquad regression: fail");
    $finish;
  end

endmodule
